// File: rtl/gbba_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the grouped bitmap block allocator.
// No dependencies; imported by every module of the block.
package gbba_pkg;

	localparam int MAX_BLOCKS = 4096;
	localparam int BLK_W      = 12;
	localparam int CFG_W      = 13;
	localparam int LIM_W      = 13;
	localparam int PROD_W     = 2 * CFG_W;
	localparam int WORD_W     = 64;
	localparam int BIT_W      = 6;
	localparam int WORDS      = MAX_BLOCKS / WORD_W;
	localparam int ADDR_W     = BLK_W - BIT_W;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_FIND  = 2'd2;

	localparam logic CFG_BLOCKS_PER_GROUP = 1'b0;
	localparam logic CFG_GROUP_COUNT      = 1'b1;

	localparam logic [CFG_W-1:0] BPG_RESET = CFG_W'(4096);
	localparam logic [CFG_W-1:0] GC_RESET  = CFG_W'(1);

	typedef struct packed {
		logic [1:0]       req_type;
		logic [BLK_W-1:0] block_index;
	} gbba_in_t;

	typedef struct packed {
		logic             found;
		logic [BLK_W-1:0] result_block;
	} gbba_out_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [WORD_W-1:0] wr_data;
	} gbba_mem_req_t;

	typedef struct packed {
		logic              hit;
		logic [BIT_W-1:0]  idx;
		logic [WORD_W-1:0] onehot;
	} gbba_hit_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_SCAN,
		S_FREE,
		S_RESP
	} gbba_state_t;

endpackage

// File: rtl/grouped_bitmap_block_allocator.sv
`timescale 1ns / 1ps
// Grouped bitmap block allocator: top level with control sequencer.
// Free: reads the word, then clears the block's bit. An unknown request answers not found.
// Allocate/find: one setup state, then one 64-block bitmap word per cycle, up to 65 words,
// none if a group setting is 0. One item at a time; the next is taken while a result waits.
// Reset (arst_n low) marks every block free at once and sets the group registers.
// Uses gbba_pkg, gbba_map_mem, gbba_word_search.
module grouped_bitmap_block_allocator import gbba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gbba_in_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output gbba_out_t        out_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	gbba_state_t state_q, state_d;

	logic [CFG_W-1:0]  bpg_q, gc_q;
	logic [1:0]        req_q, req_d;
	logic [BLK_W-1:0]  blk_q, blk_d;
	logic [LIM_W-1:0]  lim_q, lim_d;
	logic [BLK_W-1:0]  start_q, start_d;
	logic [ADDR_W-1:0] iss_w_q, iss_w_d;
	logic              iss_wrap_q, iss_wrap_d;
	logic              iss_on_q, iss_on_d;
	logic              chk_vld_s1, chk_vld_d;
	logic [ADDR_W-1:0] chk_w_s1, chk_w_d;
	logic              chk_wrap_s1, chk_wrap_d;
	logic              chk_last_s1, chk_last_d;
	gbba_out_t         res_q, res_d;
	logic              out_valid_q, out_valid_d;
	gbba_out_t         out_data_q, out_data_d;

	logic [PROD_W-1:0] prod;
	logic [WORD_W-1:0] rd_data;
	gbba_mem_req_t     mreq;
	gbba_hit_t         hit;

	gbba_map_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rd_data(rd_data)
	);

	gbba_word_search u_search (
		.word (rd_data),
		.waddr(chk_w_s1),
		.wrap (chk_wrap_s1),
		.lim  (lim_q),
		.start(start_q),
		.res  (hit)
	);

	assign prod      = gc_q * bpg_q;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpg_q <= BPG_RESET;
			gc_q  <= GC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCKS_PER_GROUP: bpg_q <= cfg_wdata;
				CFG_GROUP_COUNT:      gc_q  <= cfg_wdata;
				default:              ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iss_on_q    <= 1'b0;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			iss_on_q    <= iss_on_d;
			chk_vld_s1  <= chk_vld_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q       <= req_d;
		blk_q       <= blk_d;
		lim_q       <= lim_d;
		start_q     <= start_d;
		iss_w_q     <= iss_w_d;
		iss_wrap_q  <= iss_wrap_d;
		chk_w_s1    <= chk_w_d;
		chk_wrap_s1 <= chk_wrap_d;
		chk_last_s1 <= chk_last_d;
		res_q       <= res_d;
		out_data_q  <= out_data_d;
	end

	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		blk_d       = blk_q;
		lim_d       = lim_q;
		start_d     = start_q;
		iss_w_d     = iss_w_q;
		iss_wrap_d  = iss_wrap_q;
		iss_on_d    = iss_on_q;
		chk_vld_d   = 1'b0;
		chk_w_d     = iss_w_q;
		chk_wrap_d  = iss_wrap_q;
		chk_last_d  = chk_last_s1;
		res_d       = res_q;
		out_valid_d = out_valid_q && !out_ready;
		out_data_d  = out_data_q;
		mreq        = '0;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					req_d = in_data.req_type;
					blk_d = in_data.block_index;
					case (in_data.req_type)
						REQ_ALLOC, REQ_FIND: begin
							state_d = S_PREP;
						end
						REQ_FREE: begin
							mreq.rd_en   = 1'b1;
							mreq.rd_addr = in_data.block_index[BLK_W-1:BIT_W];
							state_d      = S_FREE;
						end
						default: begin
							res_d   = '0;
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_PREP: begin
				if (prod == '0) begin
					res_d   = '0;
					state_d = S_RESP;
				end else begin
					lim_d = (prod >= PROD_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS)
						: prod[LIM_W-1:0];
					// a hint outside the configured groups starts at block 0
					start_d    = ({{(PROD_W-BLK_W){1'b0}}, blk_q} < prod) ? blk_q : '0;
					iss_w_d    = start_d[BLK_W-1:BIT_W];
					iss_wrap_d = 1'b0;
					iss_on_d   = 1'b1;
					state_d    = S_SCAN;
				end
			end
			S_SCAN: begin
				if (iss_on_q) begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = iss_w_q;
					chk_vld_d    = 1'b1;
					chk_last_d   = iss_wrap_q && (iss_w_q == start_q[BLK_W-1:BIT_W]);
					// first pass runs to the top word, wrapped pass back to the start word
					if (!iss_wrap_q && iss_w_q == ADDR_W'(WORDS - 1)) begin
						iss_wrap_d = 1'b1;
						iss_w_d    = '0;
					end else if (iss_wrap_q && iss_w_q == start_q[BLK_W-1:BIT_W]) begin
						iss_on_d = 1'b0;
					end else begin
						iss_w_d = iss_w_q + ADDR_W'(1);
					end
				end
				if (chk_vld_s1 && hit.hit) begin
					if (req_q == REQ_ALLOC) begin
						mreq.wr_en   = 1'b1;
						mreq.wr_addr = chk_w_s1;
						mreq.wr_data = rd_data | hit.onehot;
					end
					res_d.found        = 1'b1;
					res_d.result_block = {chk_w_s1, hit.idx};
					iss_on_d           = 1'b0;
					chk_vld_d          = 1'b0;
					state_d            = S_RESP;
				end else if (chk_vld_s1 && chk_last_s1) begin
					res_d     = '0;
					iss_on_d  = 1'b0;
					chk_vld_d = 1'b0;
					state_d   = S_RESP;
				end
			end
			S_FREE: begin
				mreq.wr_en         = 1'b1;
				mreq.wr_addr       = blk_q[BLK_W-1:BIT_W];
				mreq.wr_data       = rd_data & ~(WORD_W'(1) << blk_q[BIT_W-1:0]);
				res_d.found        = 1'b1;
				res_d.result_block = blk_q;
				state_d            = S_RESP;
			end
			S_RESP: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					out_data_d  = res_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/gbba_map_mem.sv
`timescale 1ns / 1ps
// Bitmap word memory, 64 bits per word, one read and one write port.
// Per-word valid bits make unwritten words read as all free. Uses gbba_pkg.
module gbba_map_mem import gbba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  gbba_mem_req_t     req,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem_q [WORDS];
	logic [WORD_W-1:0] rdata_q;
	logic [WORDS-1:0]  valid_q;
	logic              rvld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvld_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

// File: rtl/gbba_word_search.sv
`timescale 1ns / 1ps
// Finds the lowest free block in one bitmap word inside the search window.
// Combinational; uses gbba_pkg.
module gbba_word_search import gbba_pkg::*; (
	input  logic [WORD_W-1:0] word,
	input  logic [ADDR_W-1:0] waddr,
	input  logic              wrap,
	input  logic [LIM_W-1:0]  lim,
	input  logic [BLK_W-1:0]  start,
	output gbba_hit_t         res
);

	logic [LIM_W-BIT_W-1:0] lim_word;
	logic [ADDR_W-1:0]      st_word;
	logic [WORD_W-1:0]      lim_lo;
	logic [WORD_W-1:0]      st_lo;
	logic [WORD_W-1:0]      lim_mask;
	logic [WORD_W-1:0]      pos_mask;
	logic [WORD_W-1:0]      cand;
	logic [WORD_W-1:0]      onehot;
	logic [BIT_W-1:0]       idx;

	assign lim_word = lim[LIM_W-1:BIT_W];
	assign st_word  = start[BLK_W-1:BIT_W];
	assign lim_lo   = ~({WORD_W{1'b1}} << lim[BIT_W-1:0]);
	assign st_lo    = ~({WORD_W{1'b1}} << start[BIT_W-1:0]);

	always_comb begin
		// blocks below the limit of the configured groups
		if ({1'b0, waddr} < lim_word) begin
			lim_mask = '1;
		end else if ({1'b0, waddr} == lim_word) begin
			lim_mask = lim_lo;
		end else begin
			lim_mask = '0;
		end
		// first pass: at or after the start; wrapped pass: before the start
		if (!wrap) begin
			if (waddr > st_word) begin
				pos_mask = '1;
			end else if (waddr == st_word) begin
				pos_mask = ~st_lo;
			end else begin
				pos_mask = '0;
			end
		end else begin
			if (waddr < st_word) begin
				pos_mask = '1;
			end else if (waddr == st_word) begin
				pos_mask = st_lo;
			end else begin
				pos_mask = '0;
			end
		end
	end

	assign cand   = ~word & lim_mask & pos_mask;
	assign onehot = cand & (~cand + WORD_W'(1));

	always_comb begin
		idx = '0;
		for (int j = 0; j < WORD_W; j++) begin
			if (onehot[j]) begin
				idx = idx | BIT_W'(j);
			end
		end
	end

	assign res.hit    = |cand;
	assign res.idx    = idx;
	assign res.onehot = onehot;

endmodule
